// File: src/wtg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the tone generator.
package wtg_pkg;

    // Datapath sizes.
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int LENGTH_BITS     = 24;

    // Width of the phase word that selects the waveform value.
    localparam int WAVE_PHASE_BITS = 16;

    // Quarter-wave table geometry: one entry per table step plus the end point.
    localparam int SINE_QSHIFT     = WAVE_PHASE_BITS - SINE_TABLE_BITS;
    localparam int SINE_QUARTER    = 2 ** (SINE_TABLE_BITS - 2);
    localparam int SINE_ENTRIES    = SINE_QUARTER + 1;
    localparam int SINE_ADDR_BITS  = SINE_TABLE_BITS - 1;
    localparam int SINE_DATA_BITS  = 15;

    // Polynomial coefficients of the quarter-wave sine, Q15.
    localparam longint unsigned SIN_A = 64'd51472;
    localparam longint unsigned SIN_B = 64'd21024;
    localparam longint unsigned SIN_C = 64'd2320;

    // Noise generator seed and feedback taps.
    localparam logic [31:0] NOISE_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;

    // Register map: register index is the word address.
    localparam int CFG_ADDR_BITS = 4;
    typedef enum logic [1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_WAVEFORM    = 2'd1,
        REG_AMPLITUDE   = 2'd2,
        REG_TONE_LENGTH = 2'd3
    } t_reg_idx;

    // Waveform select codes; the remaining codes give silence.
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_SAWTOOTH = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    localparam logic [15:0] AMPLITUDE_RESET = 16'd32768;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [31:0] phase_step;
        logic [2:0]  waveform;
        logic [15:0] amplitude;
        logic [23:0] tone_length;
    } t_cfg;

    // One entry of the state memory.
    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic [LENGTH_BITS-1:0] count;
        logic [31:0]            noise;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: '0,
        count: '0,
        noise: NOISE_SEED
    };

    // What the state update hands to the waveform pipeline for one sample.
    typedef struct packed {
        logic [WAVE_PHASE_BITS-1:0] phase;
        logic                       active;
        logic                       last;
        logic [15:0]                noise;
    } t_front;

    typedef logic [SINE_DATA_BITS-1:0] t_sine_tab [0:SINE_ENTRIES-1];

    // Evaluates the quarter-wave polynomial at every table point.
    function automatic t_sine_tab build_sine();
        t_sine_tab       tab;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            z  = longint'(k) << (SINE_QSHIFT + 1);
            z2 = (z * z) >> 15;
            t  = (SIN_C * z2) >> 15;
            t  = SIN_B - t;
            t  = (t * z2) >> 15;
            t  = SIN_A - t;
            t  = (t * z) >> 15;
            if (t > 64'd32767) begin
                t = 64'd32767;
            end
            tab[k] = SINE_DATA_BITS'(t);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

// File: src/wtg_apb_regs.sv
// Configuration register file behind the APB-style port.
module wtg_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtg_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output wtg_pkg::t_cfg                     o_cfg
);

    wtg_pkg::t_cfg    r_cfg;
    wtg_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = wtg_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes, each masked to its width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step  <= '0;
            r_cfg.waveform    <= wtg_pkg::WAVE_SINE;
            r_cfg.amplitude   <= wtg_pkg::AMPLITUDE_RESET;
            r_cfg.tone_length <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                wtg_pkg::REG_PHASE_STEP:  r_cfg.phase_step  <= pwdata;
                wtg_pkg::REG_WAVEFORM:    r_cfg.waveform    <= pwdata[2:0];
                wtg_pkg::REG_AMPLITUDE:   r_cfg.amplitude   <= pwdata[15:0];
                wtg_pkg::REG_TONE_LENGTH: r_cfg.tone_length <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Read back of the addressed register.
    always_comb begin
        case (reg_idx)
            wtg_pkg::REG_PHASE_STEP:  prdata = r_cfg.phase_step;
            wtg_pkg::REG_WAVEFORM:    prdata = {29'd0, r_cfg.waveform};
            wtg_pkg::REG_AMPLITUDE:   prdata = {16'd0, r_cfg.amplitude};
            wtg_pkg::REG_TONE_LENGTH: prdata = {8'd0, r_cfg.tone_length};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/wtg_state_mem.sv
// Single-entry state memory with registered read, write forwarding and a valid bit.
module wtg_state_mem (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  wtg_pkg::t_state i_wdata,
    output wtg_pkg::t_state o_rdata
);

    wtg_pkg::t_state mem [0:0];
    wtg_pkg::t_state r_rd;
    wtg_pkg::t_state r_wdata;
    logic            r_init;
    logic            r_fwd;

    // Memory array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[0] <= i_wdata;
        end
        r_rd <= mem[0];
    end

    // Copy of the last write, used while the read register is one write behind.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_wdata <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            r_fwd <= i_we;
            if (i_we) begin
                r_init <= 1'b1;
            end
        end
    end

    // An entry never written since reset reads as the reset state.
    always_comb begin
        if (!r_init) begin
            o_rdata = wtg_pkg::STATE_RESET;
        end else if (r_fwd) begin
            o_rdata = r_wdata;
        end else begin
            o_rdata = r_rd;
        end
    end

endmodule

// File: src/wtg_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module wtg_sine_rom (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [wtg_pkg::SINE_ADDR_BITS-1:0]  i_addr,
    output logic [wtg_pkg::SINE_DATA_BITS-1:0]  o_data
);

    logic [wtg_pkg::SINE_DATA_BITS-1:0] r_data;

    // Read data moves only when the stage that consumes it advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= wtg_pkg::SINE_TAB[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// File: src/wtg_shaper.sv
// Waveform pipeline: table read, waveform select and gain, rounding and saturation.
module wtg_shaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wtg_pkg::t_cfg       i_cfg,
    input  logic                i_front_valid,
    input  wtg_pkg::t_front     i_front,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output logic signed [15:0]  o_sample,
    output logic                o_active,
    output logic                o_last
);

    localparam int QB = wtg_pkg::SINE_TABLE_BITS - 2;

    // Stage enables: a stage advances when it is empty or the next one advances.
    logic en1;
    logic en2;
    logic en3;

    logic                r_s1_valid;
    logic [15:0]         r_s1_phase;
    logic                r_s1_active;
    logic                r_s1_last;
    logic [15:0]         r_s1_noise;

    logic                r_s2_valid;
    logic signed [33:0]  r_s2_prod;
    logic                r_s2_active;
    logic                r_s2_last;

    logic                r_out_valid;
    logic signed [15:0]  r_out_sample;
    logic                r_out_active;
    logic                r_out_last;

    logic [QB-1:0]                          rom_ridx;
    logic [wtg_pkg::SINE_ADDR_BITS-1:0]     rom_addr;
    logic [wtg_pkg::SINE_DATA_BITS-1:0]     rom_data;

    logic signed [16:0]  sine17;
    logic signed [16:0]  saw17;
    logic signed [16:0]  abs17;
    logic signed [17:0]  tri18;
    logic signed [16:0]  raw;
    logic signed [16:0]  gain17;
    logic signed [33:0]  prod;
    logic signed [33:0]  biased;
    logic signed [18:0]  quot;
    logic signed [15:0]  sat;

    assign en3     = !r_out_valid || !i_stall;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;

    // Table address: the quarter index, mirrored in the odd quadrants.
    assign rom_ridx = i_front.phase[13:wtg_pkg::SINE_QSHIFT];
    always_comb begin
        if (i_front.phase[14]) begin
            rom_addr = wtg_pkg::SINE_ADDR_BITS'(wtg_pkg::SINE_QUARTER)
                     - {1'b0, rom_ridx};
        end else begin
            rom_addr = {1'b0, rom_ridx};
        end
    end

    wtg_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (en1),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Stage 1 holds the sample's phase, flags and noise while the table is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_phase  <= i_front.phase;
            r_s1_active <= i_front.active;
            r_s1_last   <= i_front.last;
            r_s1_noise  <= i_front.noise;
        end
    end

    // Raw waveform value in Q15, one bit wider to hold plus one.
    assign sine17 = r_s1_phase[15] ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});
    assign saw17  = $signed({r_s1_phase[15], r_s1_phase});
    assign abs17  = r_s1_phase[15] ? -saw17 : saw17;
    assign tri18  = ($signed({abs17, 1'b0})) - 18'sd32768;

    always_comb begin
        case (i_cfg.waveform)
            wtg_pkg::WAVE_SINE:     raw = sine17;
            wtg_pkg::WAVE_SQUARE:   raw = r_s1_phase[15] ? -17'sd32767 : 17'sd32767;
            wtg_pkg::WAVE_SAWTOOTH: raw = saw17;
            wtg_pkg::WAVE_TRIANGLE: raw = tri18[16:0];
            wtg_pkg::WAVE_NOISE:    raw = $signed({r_s1_noise[15], r_s1_noise});
            default:                raw = '0;
        endcase
        if (!r_s1_active) begin
            raw = '0;
        end
    end

    // Gain multiply, registered before rounding.
    assign gain17 = $signed({1'b0, i_cfg.amplitude});
    assign prod   = raw * gain17;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_prod   <= prod;
            r_s2_active <= r_s1_active;
            r_s2_last   <= r_s1_last;
        end
    end

    // Round to nearest, floor shift back to Q15 and saturate to 16 bits.
    assign biased = r_s2_prod + 34'sd16384;
    assign quot   = biased[33:15];

    always_comb begin
        if (quot > 19'sd32767) begin
            sat = 16'sh7FFF;
        end else if (quot < -19'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = quot[15:0];
        end
    end

    // Output register, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out_sample <= sat;
            r_out_active <= r_s2_active;
            r_out_last   <= r_s2_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_active = r_out_active;
    assign o_last   = r_out_last;

endmodule

// File: src/waveform_tone_generator.sv
// Top level of the tone generator: state update around the state memory, pipeline and registers.
//
//   Port group   Direction  Handshake            Payload
//   input        in         i_valid / o_stall    i_restart
//   output       out        o_valid / i_stall    o_sample, o_active, o_last
//   config       in         psel, penable, ...   paddr, pwdata, prdata
//
// One sample per clock cycle when the output is not stalled; after its transfer in, a
// sample passes the table read, gain multiply, and round and saturate stages in order.
// The phase, sample count and noise state sit in a one-entry memory that is read,
// updated by one add and compare, and written back in the transfer cycle; a transfer
// that follows directly takes the forwarded write data, a later one the read data.
// Reset is synchronous and active low; the state reads as its reset value until
// the first write, so no clearing pass is needed.
// A stall at the output holds the output register; earlier stages keep filling,
// and the input stalls only once all three stages are full.
module waveform_tone_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_restart,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [15:0]                o_sample,
    output logic                              o_active,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtg_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int PB = wtg_pkg::PHASE_BITS;
    localparam int LB = wtg_pkg::LENGTH_BITS;

    wtg_pkg::t_cfg   cfg;
    wtg_pkg::t_state cur_state;
    wtg_pkg::t_state n_state;
    wtg_pkg::t_front front;

    logic          ready;
    logic          accept;
    logic [PB-1:0] phase0;
    logic [LB-1:0] count0;
    logic [LB-1:0] len;
    logic [LB-1:0] count_inc;
    logic          act;

    assign pready = 1'b1;

    wtg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign accept  = i_valid && ready;
    assign o_stall = !ready;

    wtg_state_mem u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_wdata (n_state),
        .o_rdata (cur_state)
    );

    // State update: restart clears phase and count, then an active sample advances them.
    assign phase0    = i_restart ? '0 : cur_state.phase;
    assign count0    = i_restart ? '0 : cur_state.count;
    assign len       = LB'(cfg.tone_length);
    assign act       = count0 < len;
    assign count_inc = count0 + 1'b1;

    always_comb begin
        n_state.phase = act ? phase0 + PB'(cfg.phase_step) : phase0;
        n_state.count = act ? count_inc : count0;
        if (cur_state.noise[0]) begin
            n_state.noise = (cur_state.noise >> 1) ^ wtg_pkg::NOISE_TAPS;
        end else begin
            n_state.noise = cur_state.noise >> 1;
        end
    end

    // Per-sample values handed to the waveform pipeline.
    always_comb begin
        front.phase  = phase0[PB-1 -: wtg_pkg::WAVE_PHASE_BITS];
        front.active = act;
        front.last   = act && (count_inc == len);
        front.noise  = cur_state.noise[15:0];
    end

    wtg_shaper u_shaper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_front_valid (accept),
        .i_front       (front),
        .i_stall       (i_stall),
        .o_ready       (ready),
        .o_valid       (o_valid),
        .o_sample      (o_sample),
        .o_active      (o_active),
        .o_last        (o_last)
    );

    // An inactive sample is silent and never marks the end of the tone.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_sample == 16'sd0 && !o_last)
        else $error("inactive sample is not silent");

    // The state read after a transfer is exactly what that transfer wrote back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> cur_state == $past(n_state))
        else $error("state forwarding lost a write");

    // The input stalls only when the output holds a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without an output stall");

    // The sample counter never passes the tone length after an active sample.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && act |=> cur_state.count <= $past(len))
        else $error("sample counter ran past the tone length");

endmodule

// File: test/waveform_tone_generator_tb.sv
// Self-checking testbench for the tone generator: directed and random tones, checked in order.
module waveform_tone_generator_tb;

    // One expected output transfer.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
        logic               last;
    } t_tone;

    logic                              i_clk     = 1'b0;
    logic                              i_rst_n   = 1'b0;
    logic                              i_valid   = 1'b0;
    logic                              o_stall;
    logic                              i_restart = 1'b0;
    logic                              o_valid;
    logic                              i_stall   = 1'b0;
    logic signed [15:0]                o_sample;
    logic                              o_active;
    logic                              o_last;
    logic                              psel      = 1'b0;
    logic                              penable   = 1'b0;
    logic                              pwrite    = 1'b0;
    logic [wtg_pkg::CFG_ADDR_BITS-1:0] paddr     = '0;
    logic [31:0]                       pwdata    = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    // Register copies as the block should hold them.
    logic [31:0]                     step_cfg   = '0;
    logic [2:0]                      wave_cfg   = wtg_pkg::WAVE_SINE;
    logic [15:0]                     gain_cfg   = wtg_pkg::AMPLITUDE_RESET;
    logic [wtg_pkg::LENGTH_BITS-1:0] length_cfg = '0;

    // Oscillator state of the prediction.
    logic [wtg_pkg::PHASE_BITS-1:0]  phase_acc  = '0;
    logic [wtg_pkg::LENGTH_BITS-1:0] sample_cnt = '0;
    logic [31:0]                     lfsr       = wtg_pkg::NOISE_SEED;

    logic  restart_q [$];
    t_tone tone_q [$];
    t_tone head;
    bit    item_held   = 1'b0;
    bit    calm        = 1'b0;
    int    in_gap      = 0;
    int    out_hold    = 0;
    int    fault_count = 0;
    int    queued      = 0;

    waveform_tone_generator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_restart(i_restart),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_sample (o_sample),
        .o_active (o_active),
        .o_last   (o_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // Sine over the first quarter turn, u from 0 to 16384, in Q15 and capped.
    function automatic int quarter_wave(input int unsigned u);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        z  = longint'(u) << 1;
        z2 = (z * z) >> 15;
        t  = (longint'(2320) * z2) >> 15;
        t  = longint'(21024) - t;
        t  = (t * z2) >> 15;
        t  = longint'(51472) - t;
        t  = (t * z) >> 15;
        if (t > 32767) begin
            t = 32767;
        end
        return int'(t);
    endfunction

    // Unscaled waveform value for the top 16 phase bits.
    function automatic int wave_value(input logic [15:0] p);
        logic [15:0] x;
        int          v;
        int          s;
        case (wave_cfg)
            wtg_pkg::WAVE_SINE: begin
                // The sine only sees the phase bits that address its table.
                x = p & ~16'((1 << (16 - wtg_pkg::SINE_TABLE_BITS)) - 1);
                v = x[14] ? quarter_wave(16384 - x[13:0]) : quarter_wave(x[13:0]);
                return x[15] ? -v : v;
            end
            wtg_pkg::WAVE_SQUARE:   return p[15] ? -32767 : 32767;
            wtg_pkg::WAVE_SAWTOOTH: return int'($signed(p));
            wtg_pkg::WAVE_TRIANGLE: begin
                s = int'($signed(p));
                if (s < 0) begin
                    s = -s;
                end
                return 2 * s - 32768;
            end
            wtg_pkg::WAVE_NOISE:    return int'($signed(lfsr[15:0]));
            default:                return 0;
        endcase
    endfunction

    // Gain in Q1.15 with rounding, then saturation to 16 bits.
    function automatic logic signed [15:0] apply_gain(input int raw);
        longint prod;
        prod = (longint'(raw) * longint'(gain_cfg) + 16384) >>> 15;
        if (prod > 32767) begin
            prod = 32767;
        end else if (prod < -32768) begin
            prod = -32768;
        end
        return 16'(prod);
    endfunction

    // Works out the output of one input transfer and advances the oscillator.
    task automatic predict_tone(input logic restart);
        t_tone want;
        want = '0;
        if (restart) begin
            phase_acc  = '0;
            sample_cnt = '0;
        end
        if (sample_cnt < length_cfg) begin
            want.sample = apply_gain(wave_value(phase_acc[wtg_pkg::PHASE_BITS-1 -: 16]));
            want.active = 1'b1;
            want.last   = ({1'b0, sample_cnt} + 1'b1) == {1'b0, length_cfg};
            phase_acc   = phase_acc + step_cfg;
            sample_cnt  = sample_cnt + 1'b1;
        end
        // The noise register steps on every transfer, active or not.
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ wtg_pkg::NOISE_TAPS) : (lfsr >> 1);
        tone_q.push_back(want);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input wtg_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wtg_pkg::CFG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wtg_pkg::REG_PHASE_STEP:  step_cfg   = value;
            wtg_pkg::REG_WAVEFORM:    wave_cfg   = value[2:0];
            wtg_pkg::REG_AMPLITUDE:   gain_cfg   = value[15:0];
            wtg_pkg::REG_TONE_LENGTH: length_cfg = value[wtg_pkg::LENGTH_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_tone(input logic [31:0] step, input logic [31:0] wave,
                            input logic [31:0] gain, input logic [31:0] len);
        write_reg(wtg_pkg::REG_PHASE_STEP, step);
        write_reg(wtg_pkg::REG_WAVEFORM, wave);
        write_reg(wtg_pkg::REG_AMPLITUDE, gain);
        write_reg(wtg_pkg::REG_TONE_LENGTH, len);
    endtask

    // Queues n inputs; pct is the chance in percent of a restart after the first.
    task automatic queue_run(input int n, input bit first_restart, input int pct);
        for (int k = 0; k < n; k++) begin
            restart_q.push_back(k == 0 ? first_restart : ($urandom_range(0, 99) < pct));
        end
        queued += n;
    endtask

    // Waits until every queued input has been sent and every sample checked.
    task automatic drain();
        while (restart_q.size() != 0 || item_held || tone_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    // Input driver: presents one item at a time and holds it until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!item_held) begin
            if (in_gap > 0) begin
                in_gap--;
                i_valid <= 1'b0;
            end else if (restart_q.size() != 0) begin
                i_restart <= restart_q.pop_front();
                i_valid   <= 1'b1;
                item_held = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(1, 16);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Input side: every transfer in gets its expected output.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_tone(i_restart);
            item_held = 1'b0;
        end
    end

    // Output stall in random bursts.
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            i_stall <= 1'b1;
        end else if (!calm && i_rst_n && $urandom_range(0, 7) == 0) begin
            out_hold = $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Output side: each transfer out is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tone_q.size() == 0) begin
                $error("unexpected output: sample %0d active %0b last %0b",
                       o_sample, o_active, o_last);
                fault_count++;
            end else begin
                head = tone_q.pop_front();
                if (o_sample !== head.sample) begin
                    $error("sample: expected %0d, got %0d", head.sample, o_sample);
                    fault_count++;
                end
                if (o_active !== head.active) begin
                    $error("active: expected %0b, got %0b", head.active, o_active);
                    fault_count++;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %0b, got %0b", head.last, o_last);
                    fault_count++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        logic [31:0] step;
        logic [31:0] wave;
        logic [31:0] gain;
        logic [31:0] len;
        int          pick;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers give a zero-length tone that never becomes active.
        queue_run(2, 1'b1, 0);
        drain();
        // Sine at quarter turns; the fourth sample falls past the end of the tone.
        set_tone(32'h4000_0000, 32'(wtg_pkg::WAVE_SINE), 32'd32768, 32'd3);
        queue_run(4, 1'b1, 0);
        drain();
        // Full-scale square at the largest gain saturates both ways.
        set_tone(32'h8000_0000, 32'(wtg_pkg::WAVE_SQUARE), 32'h0000_FFFF, 32'd2);
        queue_run(2, 1'b1, 0);
        drain();
        // Triangle at its ends and middle with the largest gain.
        set_tone(32'h4000_0000, 32'(wtg_pkg::WAVE_TRIANGLE), 32'h0000_FFFF, 32'd3);
        queue_run(3, 1'b1, 0);
        drain();
        // Sawtooth with zero gain stays silent while active.
        set_tone(32'h1234_5678, 32'(wtg_pkg::WAVE_SAWTOOTH), 32'd0, 32'd2);
        queue_run(2, 1'b1, 0);
        drain();
        // Noise with a zero phase step.
        set_tone(32'd0, 32'(wtg_pkg::WAVE_NOISE), 32'd32768, 32'd2);
        queue_run(2, 1'b0, 0);
        drain();
        // Unused waveform code, largest step and length, upper bits to be dropped.
        set_tone(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_8000, 32'hFFFF_FFFF);
        queue_run(2, 1'b0, 0);
        drain();

        // Random tones; the last part runs without idling on either side.
        while (queued < 850) begin
            if (queued >= 700) begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 9);
            step = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                   (pick < 6) ? $urandom_range(1, 32'h0800_0000) : $urandom;
            wave = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0) begin
                wave = wave | ($urandom & ~32'h7);
            end
            pick = $urandom_range(0, 9);
            gain = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h0000_FFFF :
                   (pick == 2) ? 32'd32768 : $urandom_range(0, 65535);
            pick = $urandom_range(0, 11);
            len  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h00FF_FFFF :
                   (pick == 2) ? $urandom : $urandom_range(1, 60);
            set_tone(step, wave, gain, len);
            queue_run($urandom_range(20, 60), $urandom_range(0, 3) != 0,
                      ($urandom_range(0, 4) == 0) ? 30 : 2);
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
src/wtg_pkg.sv
src/wtg_apb_regs.sv
src/wtg_state_mem.sv
src/wtg_sine_rom.sv
src/wtg_shaper.sv
src/waveform_tone_generator.sv
test/waveform_tone_generator_tb.sv
